>>> hdl/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg
// shared types and fixed widths for the so3 attitude error pipeline
// ----------------------------------------------------------------------------
package sae_pkg;

    // quaternion component, signed q1.frac
    typedef logic signed [15:0] t_comp;
    // product of two components
    typedef logic signed [31:0] t_prod;
    // sum of four products
    typedef logic signed [33:0] t_qsum;
    // magnitude of a sum of four products
    typedef logic [32:0] t_mag;

    // norm squared of one quaternion
    localparam int NORM_W = 33;
    // |c|^2 * |d|^2
    localparam int DEN_W  = 65;
    // partial remainder, one bit above the divisor
    localparam int REM_W  = 66;

    // quaternion component order
    localparam int QW_IDX = 0;
    localparam int QX_IDX = 1;
    localparam int QY_IDX = 2;
    localparam int QZ_IDX = 3;

endpackage

>>> hdl/so3_attitude_error.sv
// ----------------------------------------------------------------------------
// so3_attitude_error
// geometric attitude error 0.5*vee(Rd^T R - R^T Rd) from two quaternions
// ----------------------------------------------------------------------------
//  channel  | direction | fields                       | flow control
//  ---------+-----------+------------------------------+---------------------
//  in       | sink      | i_cur_w..z, i_des_w..z       | i_valid / o_stall
//  out      | source    | o_err_x/y/z, o_degenerate    | o_valid / i_stall
//
//  one beat enters per cycle while o_stall is low; the pipe holds
//  three arithmetic stages, FRAC_BITS + 1 quotient-bit stages and one rounding
//  and output stage; the quotient-bit chain sets the depth
//  all stages advance together whenever the output register is empty or taken
//  reset (i_rst_n low, synchronous) clears every valid bit; no other state
// ----------------------------------------------------------------------------
module so3_attitude_error #(
    parameter int FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sae_pkg::t_comp      i_cur_w,
    input  sae_pkg::t_comp      i_cur_x,
    input  sae_pkg::t_comp      i_cur_y,
    input  sae_pkg::t_comp      i_cur_z,
    input  sae_pkg::t_comp      i_des_w,
    input  sae_pkg::t_comp      i_des_x,
    input  sae_pkg::t_comp      i_des_y,
    input  sae_pkg::t_comp      i_des_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_err_x,
    output logic signed [15:0]  o_err_y,
    output logic signed [15:0]  o_err_z,
    output logic                o_degenerate
);
    import sae_pkg::*;

    // quotient width, with room for the rounding carry
    localparam int QW    = FRAC_BITS + 2;
    localparam int NDIV  = FRAC_BITS + 1;
    // width used for the saturation compare
    localparam int SATW  = (QW > 17) ? QW : 17;

    // whole pipe moves when the output register is free
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage 1: all cross products and squares ---------------
    t_comp c [4];
    t_comp d [4];
    assign c[QW_IDX] = i_cur_w;
    assign c[QX_IDX] = i_cur_x;
    assign c[QY_IDX] = i_cur_y;
    assign c[QZ_IDX] = i_cur_z;
    assign d[QW_IDX] = i_des_w;
    assign d[QX_IDX] = i_des_x;
    assign d[QY_IDX] = i_des_y;
    assign d[QZ_IDX] = i_des_z;

    logic  r_v1;
    t_prod r_p  [4][4];   // d[i] * c[j]
    t_prod r_sc [4];
    t_prod r_sd [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p[i][j] <= t_prod'(d[i]) * t_prod'(c[j]);
                end
                r_sc[i] <= t_prod'(c[i]) * t_prod'(c[i]);
                r_sd[i] <= t_prod'(d[i]) * t_prod'(d[i]);
            end
        end
    end

    // ---------------- stage 2: error quaternion and norms -------------------
    // qe = conj(d) (x) c
    logic               r_v2;
    t_qsum              r_ew, r_ex, r_ey, r_ez;
    logic [NORM_W-1:0]  r_nc, r_nd;

    function automatic t_qsum sx(input t_prod p);
        return t_qsum'(p);
    endfunction

    function automatic logic [NORM_W-1:0] usum(input t_prod a, input t_prod b,
                                               input t_prod e, input t_prod f);
        return NORM_W'($unsigned(a)) + NORM_W'($unsigned(b))
             + NORM_W'($unsigned(e)) + NORM_W'($unsigned(f));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ew <= sx(r_p[0][0]) + sx(r_p[1][1]) + sx(r_p[2][2]) + sx(r_p[3][3]);
            r_ex <= sx(r_p[0][1]) - sx(r_p[1][0]) - sx(r_p[2][3]) + sx(r_p[3][2]);
            r_ey <= sx(r_p[0][2]) + sx(r_p[1][3]) - sx(r_p[2][0]) - sx(r_p[3][1]);
            r_ez <= sx(r_p[0][3]) - sx(r_p[1][2]) + sx(r_p[2][1]) - sx(r_p[3][0]);
            // squares are never negative, so plain unsigned sums
            r_nc <= usum(r_sc[0], r_sc[1], r_sc[2], r_sc[3]);
            r_nd <= usum(r_sd[0], r_sd[1], r_sd[2], r_sd[3]);
        end
    end

    // ---------------- stage 3: numerators 2|ew||ev| and the divisor ---------
    function automatic t_mag mag(input t_qsum v);
        t_qsum a;
        a = (v < 0) ? -v : v;
        return a[32:0];
    endfunction

    t_mag               m_w;
    t_mag               m_v [3];
    logic [65:0]        prod [3];
    logic [65:0]        den_full;
    logic               sgn [3];

    assign m_w    = mag(r_ew);
    assign m_v[0] = mag(r_ex);
    assign m_v[1] = mag(r_ey);
    assign m_v[2] = mag(r_ez);
    assign sgn[0] = r_ew[33] ^ r_ex[33];
    assign sgn[1] = r_ew[33] ^ r_ey[33];
    assign sgn[2] = r_ew[33] ^ r_ez[33];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            prod[l] = 66'(m_w) * 66'(m_v[l]);
        end
        den_full = 66'(r_nc) * 66'(r_nd);
    end

    // division pipe, index 0 holds the stage 3 registers
    logic                r_dv   [NDIV+1];
    logic                r_dg   [NDIV+1];
    logic [DEN_W-1:0]    r_den  [NDIV+1];
    logic [REM_W-1:0]    r_rem  [NDIV+1][3];
    logic [QW-1:0]       r_q    [NDIV+1][3];
    logic                r_sg   [NDIV+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dg[0]  <= (r_nc == '0) || (r_nd == '0);
            r_den[0] <= den_full[DEN_W-1:0];
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= {prod[l][REM_W-2:0], 1'b0};
                r_q[0][l]   <= '0;
                r_sg[0][l]  <= sgn[l];
            end
        end
    end

    // ---------------- quotient bit stages, one bit per stage ----------------
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [REM_W-1:0] sh  [3];
        logic [REM_W-1:0] nrm [3];
        logic             ge  [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                // first step compares the numerator itself
                sh[l]  = (k == 0) ? r_rem[k][l] : {r_rem[k][l][REM_W-2:0], 1'b0};
                ge[l]  = sh[l] >= REM_W'(r_den[k]);
                nrm[l] = ge[l] ? sh[l] - REM_W'(r_den[k]) : sh[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dg[k+1]  <= r_dg[k];
                r_den[k+1] <= r_den[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k+1][l] <= nrm[l];
                    r_q[k+1][l]   <= {r_q[k][l][QW-2:0], ge[l]};
                    r_sg[k+1][l]  <= r_sg[k][l];
                end
            end
        end
    end

    // ---------------- round half away, saturate, apply sign -----------------
    logic [15:0] res [3];

    always_comb begin
        logic [REM_W:0]  twice;
        logic [SATW-1:0] qr;
        logic [16:0]     m17;
        for (int l = 0; l < 3; l++) begin
            twice = {r_rem[NDIV][l], 1'b0};
            qr    = SATW'(r_q[NDIV][l]) + SATW'(twice >= (REM_W+1)'(r_den[NDIV]));
            m17   = (qr > SATW'(32768)) ? 17'd32768 : qr[16:0];
            if (r_sg[NDIV][l]) begin
                res[l] = 16'(-m17);
            end else if (m17 == 17'd32768) begin
                res[l] = 16'd32767;
            end else begin
                res[l] = m17[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dv[NDIV];
        end
    end

    // zero norm: error forced to zero, quotient is meaningless there
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_degenerate <= r_dg[NDIV];
            o_err_x      <= r_dg[NDIV] ? '0 : res[0];
            o_err_y      <= r_dg[NDIV] ? '0 : res[1];
            o_err_z      <= r_dg[NDIV] ? '0 : res[2];
        end
    end

endmodule
